// ===== sv/rpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsd_pkg: shared types and constants of the RLE pixel stream decoder
// Payload structs, register indexes, format codes and colour expansion.
// ----------------------------------------------------------------------------
package rpsd_pkg;

  // Default width of the remaining pixel counter
  localparam int unsigned COUNT_BITS_DEF  = 32;
  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSED   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_TOTAL  = 2'd2;

  // Packet header and channel masks
  localparam logic [7:0] HDR_RUN   = 8'h80;
  localparam logic [7:0] HDR_COUNT = 8'h7f;
  localparam logic [7:0] MASK5     = 8'hf8;
  localparam logic [7:0] MASK6     = 8'hfc;

  // Pixel formats; codes 5 to 7 decode as bgr24
  typedef enum logic [2:0] {
    FMT_MONO8    = 3'd0,
    FMT_X1R5G5B5 = 3'd1,
    FMT_R5G6B5   = 3'd2,
    FMT_BGR24    = 3'd3,
    FMT_BGRA32   = 3'd4
  } fmt_e;

  // One input item
  typedef struct packed {
    logic [7:0] byte_in;
    logic       frame_start;
  } in_t;

  // One result item
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       image_done;
  } out_t;

  // A completed pixel as the front hands it to the back
  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [23:0] pixel_bytes;
    logic [7:0]  last_byte;
    logic [7:0]  repeat_cnt;
    logic        image_done;
  } pix_t;

  // Queue occupancy as seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Bytes per pixel of a format code
  function automatic logic [2:0] bytes_per_pixel(logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_MONO8:    n = 3'd1;
      FMT_X1R5G5B5: n = 3'd2;
      FMT_R5G6B5:   n = 3'd2;
      FMT_BGRA32:   n = 3'd4;
      default:      n = 3'd3;
    endcase
    return n;
  endfunction

  // Expand held bytes plus the final byte into {red, green, blue, alpha}
  function automatic logic [31:0] expand_colour(logic [2:0] fmt, logic [23:0] pb,
                                                logic [7:0] last);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    b0 = pb[7:0];
    b1 = pb[15:8];
    b2 = pb[23:16];
    r  = '0;
    g  = '0;
    b  = '0;
    a  = '0;
    case (fmt)
      FMT_MONO8: begin
        r = last;
      end
      FMT_X1R5G5B5: begin
        r = {last[6:0], 1'b0} & MASK5;
        g = ({last[1:0], 6'd0} | {2'd0, b0[7:2]}) & MASK5;
        b = {b0[4:0], 3'd0} & MASK5;
      end
      FMT_R5G6B5: begin
        r = last & MASK5;
        g = ({last[2:0], 5'd0} | {3'd0, b0[7:3]}) & MASK6;
        b = {b0[4:0], 3'd0} & MASK5;
      end
      FMT_BGRA32: begin
        b = b0;
        g = b1;
        r = b2;
        a = last;
      end
      default: begin
        b = b0;
        g = b1;
        r = last;
      end
    endcase
    return {r, g, b, a};
  endfunction

endpackage

// ===== sv/rle_pixel_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pixel_stream_decoder: run-length pixel stream decoder
// Turns encoded pixel bytes into colour results with repeat counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one encoded byte per transfer, with frame_start set
//   on the first byte of an image. Output channel carries one result per
//   completed pixel: 8-bit red, green, blue, alpha, a repeat count and an
//   image_done flag. Both channels transfer when valid is high and stall low.
//   The configuration port writes pixel_format (0), compressed (1) and
//   pixel_total (2); write it only between images or while idle.
//   Throughput is one byte per cycle while in_stall_o is low. Header bytes,
//   partial pixel bytes and bytes after the last pixel give no result. A
//   completed pixel passes through the pixel queue and then the output
//   register before it shows on the output.
//   When the receiver stalls the output holds; the queue keeps taking pixels
//   until it is full, after which in_stall_o rises and bytes wait upstream.
//   Reset clears the queue and output, sets format bgr24, compression on and
//   a pixel total of one.
// ----------------------------------------------------------------------------
module rle_pixel_stream_decoder #(
  parameter int unsigned COUNT_BITS  = rpsd_pkg::COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = rpsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rpsd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rpsd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rpsd_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rpsd_pkg::out_t                   out_data_o
);

  rpsd_pkg::q_stat_t q_stat;
  rpsd_pkg::pix_t    push_data;
  rpsd_pkg::pix_t    head;
  logic              push;
  logic              pop;

  rpsd_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rpsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  rpsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A completed pixel never meets a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("pixel pushed into a full queue");

  // A pushed pixel is held in the queue at the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> !q_stat.empty)
    else $error("pushed pixel lost from queue");

  // A waiting pixel reaches a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!q_stat.empty && (!out_valid_o || !out_stall_i)) |=> out_valid_o)
    else $error("queued pixel not moved to output");

endmodule

// ===== sv/rpsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsd_front: byte classifier and packet sequencer
// Holds the configuration and decode state, takes one byte a cycle while the
// queue has room, gathers pixel bytes and queues completed pixels with repeats.
// ----------------------------------------------------------------------------
module rpsd_front #(
  parameter int unsigned COUNT_BITS = rpsd_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rpsd_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [rpsd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rpsd_pkg::in_t                      in_data_i,
  input  rpsd_pkg::q_stat_t                  q_stat_i,
  output logic                               push_o,
  output rpsd_pkg::pix_t                     push_data_o
);

  // Configuration registers
  logic [2:0]  pixel_format_q;
  logic        compressed_q;
  logic [31:0] pixel_total_q;

  // Decode state
  logic                  expect_header_q, expect_header_d;
  logic                  run_packet_q, run_packet_d;
  logic [7:0]            packet_left_q, packet_left_d;
  logic [1:0]            byte_slot_q, byte_slot_d;
  logic [23:0]           pixel_bytes_q, pixel_bytes_d;
  logic [COUNT_BITS-1:0] pixels_left_q, pixels_left_d;

  // State as seen by this byte, after a frame restart
  logic                  eff_header;
  logic                  eff_run;
  logic [7:0]            eff_packet;
  logic [1:0]            eff_slot;
  logic [23:0]           eff_bytes;
  logic [COUNT_BITS-1:0] eff_left;

  logic                  accept;
  logic [7:0]            hdr_cnt;
  logic [7:0]            rep;
  logic [2:0]            slot_inc;
  logic [COUNT_BITS-1:0] left_after;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= rpsd_pkg::FMT_BGR24;
      compressed_q   <= 1'b1;
      pixel_total_q  <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rpsd_pkg::CFG_PIXEL_FORMAT: pixel_format_q <= cfg_data_i[2:0];
        rpsd_pkg::CFG_COMPRESSED:   compressed_q   <= cfg_data_i[0];
        rpsd_pkg::CFG_PIXEL_TOTAL:  pixel_total_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Apply a frame restart ahead of decoding this byte
  always_comb begin
    if (in_data_i.frame_start) begin
      eff_header = 1'b1;
      eff_run    = 1'b0;
      eff_packet = '0;
      eff_slot   = '0;
      eff_bytes  = '0;
      eff_left   = pixel_total_q[COUNT_BITS-1:0];
    end else begin
      eff_header = expect_header_q;
      eff_run    = run_packet_q;
      eff_packet = packet_left_q;
      eff_slot   = byte_slot_q;
      eff_bytes  = pixel_bytes_q;
      eff_left   = pixels_left_q;
    end
  end

  // Header count clipped to the pixels that remain
  always_comb begin
    hdr_cnt = (in_data_i.byte_in & rpsd_pkg::HDR_COUNT) + 8'd1;
    if (COUNT_BITS'(hdr_cnt) > eff_left) begin
      hdr_cnt = eff_left[7:0];
    end
  end

  // Repeat of a completed pixel
  always_comb begin
    rep = 8'd1;
    if (compressed_q && eff_run) begin
      rep = (COUNT_BITS'(eff_packet) > eff_left) ? eff_left[7:0] : eff_packet;
      if (rep == 8'd0) begin
        rep = 8'd1;
      end
    end
  end

  assign slot_inc   = {1'b0, eff_slot} + 3'd1;
  assign left_after = eff_left - COUNT_BITS'(rep);

  // Classify the byte and advance the decode state
  always_comb begin
    expect_header_d = expect_header_q;
    run_packet_d    = run_packet_q;
    packet_left_d   = packet_left_q;
    byte_slot_d     = byte_slot_q;
    pixel_bytes_d   = pixel_bytes_q;
    pixels_left_d   = pixels_left_q;
    push_o          = 1'b0;
    if (accept) begin
      expect_header_d = eff_header;
      run_packet_d    = eff_run;
      packet_left_d   = eff_packet;
      byte_slot_d     = eff_slot;
      pixel_bytes_d   = eff_bytes;
      pixels_left_d   = eff_left;
      if (eff_left == '0) begin
        // drop bytes beyond the image
      end else if (compressed_q && eff_header) begin
        run_packet_d    = (in_data_i.byte_in & rpsd_pkg::HDR_RUN) != 8'd0;
        packet_left_d   = hdr_cnt;
        expect_header_d = 1'b0;
        byte_slot_d     = '0;
        pixel_bytes_d   = '0;
      end else if (slot_inc < rpsd_pkg::bytes_per_pixel(pixel_format_q)) begin
        case (eff_slot)
          2'd0:    pixel_bytes_d[7:0]   = in_data_i.byte_in;
          2'd1:    pixel_bytes_d[15:8]  = in_data_i.byte_in;
          2'd2:    pixel_bytes_d[23:16] = in_data_i.byte_in;
          default: ;
        endcase
        byte_slot_d = slot_inc[1:0];
      end else begin
        push_o        = 1'b1;
        byte_slot_d   = '0;
        pixel_bytes_d = '0;
        pixels_left_d = left_after;
        if (compressed_q) begin
          if (eff_run) begin
            packet_left_d   = '0;
            expect_header_d = 1'b1;
          end else begin
            if (eff_packet != 8'd0) begin
              packet_left_d = eff_packet - 8'd1;
            end
            if (eff_packet <= 8'd1) begin
              expect_header_d = 1'b1;
            end
          end
        end
      end
    end
  end

  // Completed pixel for the queue
  always_comb begin
    push_data_o.pixel_format = pixel_format_q;
    push_data_o.pixel_bytes  = eff_bytes;
    push_data_o.last_byte    = in_data_i.byte_in;
    push_data_o.repeat_cnt   = rep;
    push_data_o.image_done   = left_after == '0;
  end

  // Hold decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_header_q <= 1'b1;
      run_packet_q    <= 1'b0;
      packet_left_q   <= '0;
      byte_slot_q     <= '0;
      pixel_bytes_q   <= '0;
      pixels_left_q   <= COUNT_BITS'(1);
    end else begin
      expect_header_q <= expect_header_d;
      run_packet_q    <= run_packet_d;
      packet_left_q   <= packet_left_d;
      byte_slot_q     <= byte_slot_d;
      pixel_bytes_q   <= pixel_bytes_d;
      pixels_left_q   <= pixels_left_d;
    end
  end

endmodule

// ===== sv/rpsd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsd_queue: short queue of completed pixels
// Decouples the sequencer from the output side; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module rpsd_queue #(
  parameter int unsigned DEPTH = rpsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rpsd_pkg::pix_t    push_data_i,
  input  logic              pop_i,
  output rpsd_pkg::pix_t    head_o,
  output rpsd_pkg::q_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rpsd_pkg::pix_t   entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = count_q == CNT_W'(DEPTH);
  assign stat_o.empty = count_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = entry_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/rpsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsd_back: colour expansion and output register
// Pops a completed pixel, expands it to 8-bit channels and holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module rpsd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpsd_pkg::q_stat_t q_stat_i,
  input  rpsd_pkg::pix_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rpsd_pkg::out_t    out_data_o
);

  logic           out_valid_q, out_valid_d;
  rpsd_pkg::out_t out_data_q, out_data_d;
  logic           load;
  logic [31:0]    rgba;

  // Load when the output register is free or being taken this cycle
  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && !q_stat_i.empty;

  assign rgba = rpsd_pkg::expand_colour(head_i.pixel_format, head_i.pixel_bytes,
                                        head_i.last_byte);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = !q_stat_i.empty;
    end
    if (pop_o) begin
      out_data_d.red        = rgba[31:24];
      out_data_d.green      = rgba[23:16];
      out_data_d.blue       = rgba[15:8];
      out_data_d.alpha      = rgba[7:0];
      out_data_d.repeat_res = head_i.repeat_cnt;
      out_data_d.image_done = head_i.image_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
